FILE: hw/rtl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// shared types, constants and defaults of the polyline length threshold block
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int COORD_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF    = 4;
    localparam int LENGTH_WIDTH_DEF = 32;

    localparam int OUT_LEN_W = 32;
    localparam int THR_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [THR_W-1:0] LOWER_RESET = 10'd0;
    localparam logic [THR_W-1:0] UPPER_RESET = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SQUARE,
        ST_ROOT,
        ST_ACCUM,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic  capture;
        logic  sq_clear;
        logic  mag_en;
        axis_t axis;
        logic  sq_add;
        logic  root_step;
        logic  acc_start;
        logic  acc_add;
        logic  fiber_clear;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic enabled;
        logic active;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// sequencer: for a point that adds a segment it squares the three differences
// over a shared multiplier, steps the square root one bit a cycle and
// accumulates; at a fiber's last point it hands the result to the output register
// ----------------------------------------------------------------------------
module plt_ctrl #(
    parameter int COORD_WIDTH = plt_pkg::COORD_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  plt_pkg::status_t status,
    output plt_pkg::cmd_t    cmd
);
    import plt_pkg::*;

    localparam int ROOT_STEPS = COORD_WIDTH + 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cnt_next = '0;
                if (!status.enabled || status.first || !status.active)
                begin
                    state_next = status.last ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == ROOT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_ACCUM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ACCUM:
            begin
                state_next = status.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.axis = AXIS_X;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECIDE:
            begin
                if (!status.enabled)
                begin
                    cmd.fiber_clear = status.first | status.last;
                end
                else if (status.first || !status.active)
                begin
                    cmd.acc_start = 1'b1;
                end
                else
                begin
                    cmd.sq_clear = 1'b1;
                end
            end
            ST_SQUARE:
            begin
                cmd.mag_en = (cnt_reg != SQ_LAST);
                cmd.axis   = axis_t'(cnt_reg[1:0]);
                cmd.sq_add = (cnt_reg != '0);
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
            end
            ST_ACCUM:
            begin
                cmd.acc_add = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit        = status.out_free;
                cmd.fiber_clear = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/plt_datapath.sv
// ----------------------------------------------------------------------------
// plt_datapath
// point registers, shared squaring multiplier, bit-serial square root,
// saturating length accumulator, thresholds and output register
// ----------------------------------------------------------------------------
module plt_datapath #(
    parameter int COORD_WIDTH  = plt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS    = plt_pkg::FRAC_BITS_DEF,
    parameter int LENGTH_WIDTH = plt_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [COORD_WIDTH-1:0]  coord_x,
    input  logic signed [COORD_WIDTH-1:0]  coord_y,
    input  logic signed [COORD_WIDTH-1:0]  coord_z,
    input  logic                           first_point,
    input  logic                           last_point,
    input  logic                           fiber_enabled,
    input  logic                           cfg_we,
    input  logic [plt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plt_pkg::THR_W-1:0]      cfg_data,
    input  plt_pkg::cmd_t                  cmd,
    output plt_pkg::status_t               status,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [plt_pkg::OUT_LEN_W-1:0]  fiber_length,
    output logic                           length_valid,
    output logic                           keep_fiber
);
    import plt_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int MAG_W = CW + 1;
    localparam int SQ_W  = 2 * CW + 4;
    localparam int RT_W  = CW + 2;
    localparam int REM_W = CW + 4;
    localparam int LW    = LENGTH_WIDTH;
    localparam int SUM_W = ((LW > RT_W) ? LW : RT_W) + 1;

    logic signed [CW-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic                 first_reg, last_reg, en_reg;
    logic                 active_reg;
    logic [LW-1:0]        accum_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [RT_W-1:0]      root_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [THR_W-1:0]     lower_reg, upper_reg;
    logic                 out_valid_reg;
    logic [OUT_LEN_W-1:0] out_len_reg;
    logic                 out_lvalid_reg, out_keep_reg;

    logic signed [CW-1:0] cur_sel, prev_sel;
    logic [MAG_W-1:0]     diff;
    logic [MAG_W-1:0]     mag_next;
    logic [2*MAG_W-1:0]   square;
    logic [REM_W-1:0]     rem_shift;
    logic [REM_W-1:0]     trial;
    logic [SUM_W-1:0]     acc_sum;
    logic [LW-1:0]        acc_next;
    logic [LW-1:0]        lo_bound, hi_bound;
    logic                 keep_next;
    logic                 out_free;

    // axis select and magnitude of the difference
    always_comb
    begin
        case (cmd.axis)
            AXIS_X:
            begin
                cur_sel  = cur_x_reg;
                prev_sel = prev_x_reg;
            end
            AXIS_Y:
            begin
                cur_sel  = cur_y_reg;
                prev_sel = prev_y_reg;
            end
            AXIS_Z:
            begin
                cur_sel  = cur_z_reg;
                prev_sel = prev_z_reg;
            end
            default:
            begin
                cur_sel  = '0;
                prev_sel = '0;
            end
        endcase
    end

    assign diff     = {cur_sel[CW-1], cur_sel} - {prev_sel[CW-1], prev_sel};
    assign mag_next = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
    assign square   = mag_reg * mag_reg;

    // one result bit per step, two radicand bits per step
    assign rem_shift = {rem_reg[REM_W-3:0], sq_reg[SQ_W-1:SQ_W-2]};
    assign trial     = {root_reg, 2'b01};

    // saturating accumulate
    assign acc_sum  = SUM_W'(accum_reg) + SUM_W'(root_reg);
    assign acc_next = (acc_sum[SUM_W-1:LW] != '0) ? {LW{1'b1}} : acc_sum[LW-1:0];

    assign lo_bound  = LW'(lower_reg) << FRAC_BITS;
    assign hi_bound  = LW'(upper_reg) << FRAC_BITS;
    assign keep_next = en_reg && (accum_reg > lo_bound) && (accum_reg < hi_bound);

    assign out_free = !out_valid_reg || out_ready;

    assign status.first    = first_reg;
    assign status.last     = last_reg;
    assign status.enabled  = en_reg;
    assign status.active   = active_reg;
    assign status.out_free = out_free;

    // input point
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_x_reg <= coord_x;
            cur_y_reg <= coord_y;
            cur_z_reg <= coord_z;
            first_reg <= first_point;
            last_reg  <= last_point;
            en_reg    <= fiber_enabled;
        end
    end

    // squares and root
    always_ff @(posedge clk)
    begin
        if (cmd.mag_en)
        begin
            mag_reg <= mag_next;
        end
        if (cmd.sq_clear)
        begin
            sq_reg   <= '0;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.sq_add)
        begin
            sq_reg <= sq_reg + SQ_W'(square);
        end
        else if (cmd.root_step)
        begin
            sq_reg <= {sq_reg[SQ_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[RT_W-2:0], 1'b0};
            end
        end
    end

    // fiber state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
            accum_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_start || cmd.acc_add)
            begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                prev_z_reg <= cur_z_reg;
            end
            if (cmd.fiber_clear)
            begin
                accum_reg  <= '0;
                active_reg <= 1'b0;
            end
            else if (cmd.acc_start)
            begin
                accum_reg  <= '0;
                active_reg <= 1'b1;
            end
            else if (cmd.acc_add)
            begin
                accum_reg <= acc_next;
            end
        end
    end

    // thresholds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= LOWER_RESET;
            upper_reg <= UPPER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOWER: lower_reg <= cfg_data;
                REG_UPPER: upper_reg <= cfg_data;
                default:   lower_reg <= lower_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_len_reg    <= en_reg ? OUT_LEN_W'(accum_reg) : '0;
            out_lvalid_reg <= en_reg;
            out_keep_reg   <= keep_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fiber_length = out_len_reg;
    assign length_valid = out_lvalid_reg;
    assign keep_fiber   = out_keep_reg;

endmodule

FILE: hw/rtl/polyline_length_threshold.sv
// ----------------------------------------------------------------------------
// polyline_length_threshold
// arc length of 3d polylines with a strict length window
// ----------------------------------------------------------------------------
// points of a fiber enter on the s_axis channel one at a time; s_axis_tlast
// marks the last point of a fiber. each enabled point that does not start a
// fiber adds the floor of the euclidean distance to the previous enabled point
// to a saturating length accumulator. at the last point one item leaves on
// m_axis: the length, a valid flag and a keep flag (lower < length < upper,
// bounds given in whole units). thresholds are written on the cfg channel
// (index 0 lower, index 1 upper) only while the block is idle, a rule for
// the user that the block itself does not enforce; cfg_ready is always high.
// a point that adds a segment passes the shared squaring multiplier, once per
// axis, the square root unit, which yields one result bit per cycle, and the
// accumulator; a point that starts a fiber or is disabled skips them. the
// result sits in an output register: the next point is taken while it waits,
// and only a further result stalls until m_axis_tready takes it.
// reset clears the fiber state, the output valid and sets the thresholds to
// 0 and 1000.
// ----------------------------------------------------------------------------
module polyline_length_threshold #(
    parameter int COORD_WIDTH  = plt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS    = plt_pkg::FRAC_BITS_DEF,
    parameter int LENGTH_WIDTH = plt_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // coord_x, coord_y, coord_z, zero padding
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // first_point, fiber_enabled
    input  logic [1:0]                              s_axis_tuser,
    input  logic                                    s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // fiber_length
    output logic [plt_pkg::OUT_LEN_W-1:0]           m_axis_tdata,
    // length_valid, keep_fiber
    output logic [1:0]                              m_axis_tuser,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [plt_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [plt_pkg::THR_W-1:0]               cfg_data
);
    import plt_pkg::*;

    localparam int CW = COORD_WIDTH;

    cmd_t    cmd;
    status_t status;

    logic signed [CW-1:0] coord_x, coord_y, coord_z;

    assign coord_x   = s_axis_tdata[CW-1:0];
    assign coord_y   = s_axis_tdata[2*CW-1:CW];
    assign coord_z   = s_axis_tdata[3*CW-1:2*CW];
    assign cfg_ready = 1'b1;

    plt_ctrl #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plt_datapath #(
        .COORD_WIDTH  (COORD_WIDTH),
        .FRAC_BITS    (FRAC_BITS),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .first_point   (s_axis_tuser[0]),
        .last_point    (s_axis_tlast),
        .fiber_enabled (s_axis_tuser[1]),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .fiber_length  (m_axis_tdata),
        .length_valid  (m_axis_tuser[0]),
        .keep_fiber    (m_axis_tuser[1])
    );

endmodule

FILE: hw/rtl/plt_checker.sv
// ----------------------------------------------------------------------------
// plt_checker
// port-level checks of the polyline length threshold block
// ----------------------------------------------------------------------------
module plt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [plt_pkg::OUT_LEN_W-1:0]  m_axis_tdata,
    input logic [1:0]                     m_axis_tuser
);

    // a waiting item stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    // input ready drops once an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // keep only on a valid length
    a_keep_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("keep set on invalid length");

    // an invalid length reads as zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("invalid length not zero");

    // a kept fiber lies strictly above a nonnegative bound
    a_keep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata != '0)
        else $error("kept fiber of zero length");

endmodule

bind polyline_length_threshold plt_checker u_plt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/polyline_length_threshold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_length_threshold_tb
// self-checking bench for the polyline length threshold block
// ----------------------------------------------------------------------------
// points go in on s_axis with random bursts and gaps, results are taken on
// m_axis with a stall pattern of its own. a scoreboard class tracks the fiber
// state, works out the expected length, valid and keep flag of every fiber
// and compares them with what comes out. a directed part covers coordinate
// extremes, the window edges and the disabled, one-point, missing-start and
// restart cases; random fibers then run under several threshold windows.
// ----------------------------------------------------------------------------
module polyline_length_threshold_tb;

    import plt_pkg::*;

    localparam int CW      = COORD_WIDTH_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int TDATA_W = ((3*CW+7)/8)*8;
    localparam int RANDOM_POINTS = 1550;
    localparam int SETTLE_CYCLES = 40;

    typedef enum {RX_OPEN, RX_COIN, RX_RARE_STALL, RX_PERIODIC} rx_mode_t;
    typedef enum {FIB_CLEAN, FIB_NOISE, FIB_HOLES, FIB_NO_START, FIB_RESTART} fiber_kind_t;

    class fiber_scoreboard;
        typedef struct packed {
            logic [OUT_LEN_W-1:0] len;
            logic                 valid;
            logic                 keep;
        } fiber_result_t;

        logic signed [CW-1:0] last_x, last_y, last_z;
        logic [OUT_LEN_W-1:0] run_len;
        bit                   in_fiber;
        logic [THR_W-1:0]     lower_thr, upper_thr;
        fiber_result_t        expected_q[$];
        int                   errors;

        function new();
            last_x    = '0;
            last_y    = '0;
            last_z    = '0;
            run_len   = '0;
            in_fiber  = 0;
            lower_thr = LOWER_RESET;
            upper_thr = UPPER_RESET;
            errors    = 0;
        endfunction

        function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] v);
            if (idx == REG_LOWER)
                lower_thr = v;
            else if (idx == REG_UPPER)
                upper_thr = v;
        endfunction

        function longint unsigned dist_sq(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
            longint d;
            d = longint'(a) - longint'(b);
            return longint'(d * d);
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned r, t;
            r = 0;
            for (int b = 17; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        function void note_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                 logic signed [CW-1:0] z, bit first, bit last, bit en);
            fiber_result_t   r;
            longint unsigned seg, total;
            if (!en)
            begin
                if (first || last)
                begin
                    in_fiber = 0;
                    run_len  = '0;
                end
                if (last)
                begin
                    r = '0;
                    expected_q.insert(expected_q.size(), r);
                end
                return;
            end
            if (first || !in_fiber)
            begin
                run_len  = '0;
                in_fiber = 1;
            end
            else
            begin
                seg = floor_sqrt(dist_sq(x, last_x) + dist_sq(y, last_y) + dist_sq(z, last_z));
                total = longint'(run_len) + seg;
                run_len = (total > 64'hFFFF_FFFF) ? '1 : 32'(total);
            end
            last_x = x;
            last_y = y;
            last_z = z;
            if (last)
            begin
                r.len   = run_len;
                r.valid = 1'b1;
                r.keep  = (run_len > (32'(lower_thr) << FB)) &&
                          (run_len < (32'(upper_thr) << FB));
                expected_q.insert(expected_q.size(), r);
                in_fiber = 0;
                run_len  = '0;
            end
        endfunction

        function void check_result(logic [OUT_LEN_W-1:0] len, logic valid, logic keep);
            fiber_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected item: fiber_length %0d", len);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (len !== e.len)
            begin
                $error("fiber_length: expected %0d, actual %0d", e.len, len);
                errors++;
            end
            if (valid !== e.valid)
            begin
                $error("length_valid: expected %0d, actual %0d", e.valid, valid);
                errors++;
            end
            if (keep !== e.keep)
            begin
                $error("keep_fiber: expected %0d, actual %0d", e.keep, keep);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_LEN_W-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_data;

    fiber_scoreboard sb = new();
    int points_sent;
    int burst_left;
    int hold_cycles;

    polyline_length_threshold dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // accepted items on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_point(s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW],
                              s_axis_tdata[3*CW-1:2*CW], s_axis_tuser[0],
                              s_axis_tlast, s_axis_tuser[1]);
            if (cfg_valid && cfg_ready)
                sb.set_threshold(cfg_index, cfg_data);
        end
    end

    // result side stall pattern
    initial
    begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       rx_tick;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        rx_tick   = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_tick++;
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:       m_axis_tready <= 1'b1;
                    RX_COIN:       m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_RARE_STALL: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default:       m_axis_tready <= ((rx_tick % 7) < 3);
                endcase
            end
        end
    end

    task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input logic signed [CW-1:0] z, input bit first, input bit last,
                              input bit en);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= {en, first};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        points_sent++;
    endtask

    task automatic idle(input int n);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic pace();
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // a point that ends no fiber may still be in the root unit
    task automatic set_window(input logic [THR_W-1:0] lo, input logic [THR_W-1:0] hi);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if ($urandom_range(0, 1))
        begin
            cfg_write(REG_LOWER, lo);
            cfg_write(REG_UPPER, hi);
        end
        else
        begin
            cfg_write(REG_UPPER, hi);
            cfg_write(REG_LOWER, lo);
        end
    endtask

    task automatic random_fiber();
        int                   n, span, dx, dy, dz;
        fiber_kind_t          kind;
        bit                   f, l, e, en;
        logic signed [CW-1:0] x, y, z;
        case ($urandom_range(0, 19))
            0, 1:    kind = FIB_NOISE;
            2:       kind = FIB_HOLES;
            3:       kind = FIB_NO_START;
            4:       kind = FIB_RESTART;
            default: kind = FIB_CLEAN;
        endcase
        case ($urandom_range(0, 3))
            0:       span = 4;
            1:       span = 64;
            2:       span = 1024;
            default: span = 32767;
        endcase
        n  = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        en = ($urandom_range(0, 9) != 0);
        x  = CW'($urandom);
        y  = CW'($urandom);
        z  = CW'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                dx = int'($urandom_range(0, 2 * span)) - span;
                dy = int'($urandom_range(0, 2 * span)) - span;
                dz = int'($urandom_range(0, 2 * span)) - span;
                x  = x + dx[CW-1:0];
                y  = y + dy[CW-1:0];
                z  = z + dz[CW-1:0];
            end
            f = (i == 0);
            l = (i == n - 1);
            e = en;
            case (kind)
                FIB_NOISE:
                begin
                    f = 1'($urandom);
                    l = 1'($urandom);
                    e = 1'($urandom);
                end
                FIB_HOLES:
                    if (i > 0 && $urandom_range(0, 3) == 0)
                        e = 1'b0;
                FIB_NO_START:
                    if (i == 0)
                        f = 1'b0;
                FIB_RESTART:
                    if (i > 0 && i < n - 1 && $urandom_range(0, 4) == 0)
                        f = 1'b1;
                default: ;
            endcase
            pace();
            send_point(x, y, z, f, l, e);
        end
    endtask

    initial
    begin
        logic [THR_W-1:0] lo, hi;
        int               phase;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        points_sent   = 0;
        burst_left    = 0;
        hold_cycles   = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one-point fiber under the reset window
        send_point(0, 0, 0, 1, 1, 1);
        // full-scale diagonal there and back
        send_point(-32768, -32768, -32768, 1, 0, 1);
        send_point(32767, 32767, 32767, 0, 0, 1);
        send_point(-32768, -32768, -32768, 0, 1, 1);
        // zero-length segment
        send_point(12345, -2222, 7, 1, 0, 1);
        send_point(12345, -2222, 7, 0, 1, 1);
        // disabled fiber
        send_point(100, 200, 300, 1, 0, 0);
        send_point(-100, 50, 0, 0, 0, 0);
        send_point(900, 10, -5, 0, 1, 0);
        // missing start
        send_point(0, 0, 0, 0, 0, 1);
        send_point(48, 64, 0, 0, 1, 1);
        // disabled point inside a fiber is skipped
        send_point(0, 0, 0, 1, 0, 1);
        send_point(5000, 5000, 5000, 0, 0, 0);
        send_point(0, 0, 160, 0, 1, 1);
        // disabled start point cancels the fiber in progress
        send_point(0, 0, 0, 1, 0, 1);
        send_point(0, 0, 0, 1, 0, 0);
        send_point(100, 0, 0, 0, 0, 1);
        send_point(100, 0, 116, 0, 1, 1);
        // restart inside a fiber
        send_point(0, 0, 0, 1, 0, 1);
        send_point(1000, 0, 0, 0, 0, 1);
        send_point(0, 0, 0, 1, 0, 1);
        send_point(0, 50, 0, 0, 1, 1);

        // window edges are strict
        set_window(10'd5, 10'd10);
        send_point(0, 0, 0, 1, 0, 1);
        send_point(80, 0, 0, 0, 1, 1);
        send_point(0, 0, 0, 1, 0, 1);
        send_point(0, 159, 0, 0, 1, 1);
        send_point(0, 0, 0, 1, 0, 1);
        send_point(0, 0, 160, 0, 1, 1);

        // hold the result side until the input stalls
        drain();
        hold_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_point(CW'($urandom), CW'($urandom), CW'($urandom), 1, 1,
                       $urandom_range(0, 3) != 0);
        drain();

        points_sent = 0;
        phase = 0;
        while (points_sent < RANDOM_POINTS)
        begin
            case (phase)
                0:       begin lo = 10'd0;    hi = 10'd1023; end
                1:       begin lo = 10'd1023; hi = 10'd0;    end
                2:       begin lo = 10'd0;    hi = 10'd0;    end
                3:       begin lo = 10'd1023; hi = 10'd1023; end
                4:       begin lo = 10'd512;  hi = 10'd512;  end
                default:
                begin
                    lo = THR_W'($urandom_range(0, 300));
                    hi = THR_W'($urandom_range(lo, 1023));
                end
            endcase
            set_window(lo, hi);
            for (int k = 0; k < 60 && points_sent < RANDOM_POINTS; k++)
                random_fiber();
            phase++;
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
